### hdl/tbhc_pkg.sv
// Package for the three-button hold and combo event core.
// Holds item types, command, button, status and event codes, and sizing constants.
// No dependencies.
`default_nettype none
package tbhc_pkg;

	localparam int TBHC_TIME_BITS = 32;
	localparam int CFG_W          = 16;
	localparam int MAX_EV         = 3;
	localparam int Q_DEPTH        = 4;
	localparam logic [CFG_W-1:0] HOLD_RESET = 16'd3000;

	localparam logic [1:0] CMD_EDGE = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;
	localparam logic [1:0] CMD_POLL = 2'd2;

	localparam logic [1:0] BTN_SET  = 2'd0;
	localparam logic [1:0] BTN_UP   = 2'd1;
	localparam logic [1:0] BTN_DOWN = 2'd2;

	localparam logic [1:0] REG_SET_HOLD  = 2'd0;
	localparam logic [1:0] REG_UP_HOLD   = 2'd1;
	localparam logic [1:0] REG_DOWN_HOLD = 2'd2;

	localparam logic [2:0] EV_DOWN_REL  = 3'd0;
	localparam logic [2:0] EV_DOWN_LONG = 3'd1;
	localparam logic [2:0] EV_UP_REL    = 3'd2;
	localparam logic [2:0] EV_SET_HOLD  = 3'd3;
	localparam logic [2:0] EV_SET_UP    = 3'd4;
	localparam logic [2:0] EV_SET_DOWN  = 3'd5;
	localparam logic [2:0] EV_SET_REL   = 3'd6;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_HOLD = 2'd1,
		ST_REL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0] command;
		logic [1:0] button;
		logic       pin_level;
	} in_item_t;

	typedef struct packed {
		logic [2:0] event_code;
		logic       last_event;
	} out_item_t;

	typedef struct packed {
		logic [MAX_EV-1:0][2:0] codes;
		logic [1:0]             count;
	} batch_t;

endpackage
`default_nettype wire

### hdl/tbhc_queue.sv
// Short queue of event batches between the classifier front and the result back end.
// Depends on tbhc_pkg for the batch type and depth.
`default_nettype none
module tbhc_queue
	import tbhc_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   wr_en,
	input  wire batch_t wr_data,
	output logic        q_full,
	input  wire logic   rd_en,
	output logic        q_valid,
	output batch_t      rd_data
);

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	batch_t             entry_q [Q_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_wr;
	logic               do_rd;

	assign q_full  = (cnt_q == CNT_W'(Q_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && q_valid;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

### hdl/tbhc_front.sv
// Front end: takes requests, keeps button state, time and thresholds, and turns
// each poll into a batch of events. Depends on tbhc_pkg.
`default_nettype none
module tbhc_front
	import tbhc_pkg::*;
#(
	parameter int TIME_BITS = TBHC_TIME_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire in_item_t         item,
	input  wire logic             q_full,
	output logic                  full,
	input  wire logic             cfg_valid,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	output logic                  batch_push,
	output batch_t                batch
);

	localparam int CMP_W = (TIME_BITS > CFG_W + 1) ? TIME_BITS : CFG_W + 1;

	status_t              status_q [3];
	logic [TIME_BITS-1:0] press_q  [3];
	logic [TIME_BITS-1:0] now_q;
	logic [CFG_W-1:0]     set_hold_q;
	logic [CFG_W-1:0]     up_hold_q;
	logic [CFG_W-1:0]     down_hold_q;

	logic                 accept;
	logic [TIME_BITS-1:0] el_set;
	logic [TIME_BITS-1:0] el_up;
	logic [TIME_BITS-1:0] el_down;
	logic                 set_over;
	logic                 up_over;
	logic                 down_over;
	logic                 down_long;
	logic                 up_hold;
	logic                 down_hold;
	status_t              st_poll [3];
	logic [MAX_EV-1:0][2:0] ev_codes;
	logic [1:0]           ev_cnt;

	assign full   = q_full;
	assign accept = push && !q_full;

	assign el_set  = now_q - press_q[BTN_SET];
	assign el_up   = now_q - press_q[BTN_UP];
	assign el_down = now_q - press_q[BTN_DOWN];

	assign set_over  = CMP_W'(el_set) > CMP_W'(set_hold_q);
	assign up_over   = CMP_W'(el_up) > CMP_W'(up_hold_q);
	assign down_over = CMP_W'(el_down) > CMP_W'(down_hold_q);
	assign down_long = CMP_W'(el_down) > CMP_W'({down_hold_q, 1'b0});

	assign up_hold   = (status_q[BTN_UP] == ST_HOLD);
	assign down_hold = (status_q[BTN_DOWN] == ST_HOLD);

	always_comb begin
		st_poll  = status_q;
		ev_codes = '0;
		ev_cnt   = '0;
		if (status_q[BTN_DOWN] == ST_REL) begin
			ev_codes[ev_cnt] = EV_DOWN_REL;
			ev_cnt           = ev_cnt + 2'd1;
			st_poll[BTN_DOWN] = ST_IDLE;
		end else if (down_hold && down_long) begin
			ev_codes[ev_cnt] = EV_DOWN_LONG;
			ev_cnt           = ev_cnt + 2'd1;
		end
		if (status_q[BTN_UP] == ST_REL) begin
			ev_codes[ev_cnt] = EV_UP_REL;
			ev_cnt           = ev_cnt + 2'd1;
			st_poll[BTN_UP]  = ST_IDLE;
		end
		if (status_q[BTN_SET] == ST_HOLD && set_over) begin
			if (!up_hold && !down_hold) begin
				ev_codes[ev_cnt] = EV_SET_HOLD;
				ev_cnt           = ev_cnt + 2'd1;
				st_poll[BTN_SET] = ST_IDLE;
			end else if (up_hold && up_over) begin
				ev_codes[ev_cnt] = EV_SET_UP;
				ev_cnt           = ev_cnt + 2'd1;
				st_poll[BTN_SET] = ST_IDLE;
				st_poll[BTN_UP]  = ST_IDLE;
			end else if (down_hold && down_over) begin
				ev_codes[ev_cnt]  = EV_SET_DOWN;
				ev_cnt            = ev_cnt + 2'd1;
				st_poll[BTN_SET]  = ST_IDLE;
				st_poll[BTN_DOWN] = ST_IDLE;
			end
		end else if (status_q[BTN_SET] == ST_REL) begin
			ev_codes[ev_cnt] = EV_SET_REL;
			ev_cnt           = ev_cnt + 2'd1;
			st_poll[BTN_SET] = ST_IDLE;
		end
	end

	assign batch_push  = accept && (item.command == CMD_POLL) && (ev_cnt != '0);
	assign batch.codes = ev_codes;
	assign batch.count = ev_cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_hold_q  <= HOLD_RESET;
			up_hold_q   <= HOLD_RESET;
			down_hold_q <= HOLD_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SET_HOLD:  set_hold_q  <= cfg_data;
				REG_UP_HOLD:   up_hold_q   <= cfg_data;
				REG_DOWN_HOLD: down_hold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
			for (int i = 0; i < 3; i++) begin
				status_q[i] <= ST_IDLE;
				press_q[i]  <= '0;
			end
		end else if (accept) begin
			case (item.command)
				CMD_EDGE: begin
					if (item.button inside {BTN_SET, BTN_UP, BTN_DOWN}) begin
						if (!item.pin_level) begin
							press_q[item.button]  <= now_q;
							status_q[item.button] <= ST_HOLD;
						end else if (status_q[item.button] == ST_HOLD) begin
							status_q[item.button] <= ST_REL;
						end else begin
							status_q[item.button] <= ST_IDLE;
						end
					end
				end
				CMD_TICK: begin
					now_q <= now_q + TIME_BITS'(1);
				end
				CMD_POLL: begin
					status_q <= st_poll;
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

### hdl/tbhc_back.sv
// Back end: unpacks one event batch at a time and presents its events as results.
// Depends on tbhc_pkg for the batch and result types.
`default_nettype none
module tbhc_back
	import tbhc_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   q_valid,
	input  wire batch_t q_data,
	output logic        q_take,
	input  wire logic   pop,
	output logic        empty,
	output out_item_t   result
);

	batch_t     cur_q;
	logic       valid_q;
	logic [1:0] idx_q;
	logic       last;

	assign last   = (idx_q == cur_q.count - 2'd1);
	assign empty  = !valid_q;
	assign q_take = q_valid && (!valid_q || (pop && last));

	assign result.event_code = cur_q.codes[idx_q];
	assign result.last_event = last;

	always_ff @(posedge clk) begin
		if (q_take) begin
			cur_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (q_take) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (pop && valid_q) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

### hdl/three_button_hold_combo_events_core.sv
// Three-button hold and combo event core: front classifier, batch queue, result back end.
// Every request is taken while the batch queue has room. A poll's events are registered
// in the batch queue and then in the back end's batch register, wait there while earlier
// events are unread, and leave at one per cycle while pop is held. The four-entry batch
// queue sets how far polls may run ahead of the result side. Reset clears all statuses,
// press times and the time counter, and loads 3000 ms into every threshold.
`default_nettype none
module three_button_hold_combo_events_core
	import tbhc_pkg::*;
#(
	parameter int TIME_BITS = TBHC_TIME_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire in_item_t         item,
	output logic                  empty,
	input  wire logic             pop,
	output out_item_t             result,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	logic   q_full;
	logic   batch_push;
	batch_t batch;
	logic   q_valid;
	logic   q_take;
	batch_t q_data;

	assign cfg_ready = 1'b1;

	tbhc_front #(
		.TIME_BITS(TIME_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.q_full    (q_full),
		.full      (full),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.batch_push(batch_push),
		.batch     (batch)
	);

	tbhc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (batch_push),
		.wr_data(batch),
		.q_full (q_full),
		.rd_en  (q_take),
		.q_valid(q_valid),
		.rd_data(q_data)
	);

	tbhc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(q_valid),
		.q_data (q_data),
		.q_take (q_take),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

endmodule
`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for the three-button hold and combo event core.
// Requests go in through the push/full side and events are checked against an in-bench
// predictor as they are popped. Depends only on tbhc_pkg and the core itself.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tbhc_pkg::*;

	localparam int RUN_LIMIT = 200000;
	localparam int RANDOM_REQUESTS = 190;
	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam logic [1:0] BTN_NONE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic cfg_valid = 1'b0;
	logic [1:0] cfg_index = REG_SET_HOLD;
	logic [CFG_W-1:0] cfg_data = '0;
	in_item_t item = '0;
	wire logic full;
	wire logic empty;
	wire logic cfg_ready;
	out_item_t result;

	status_t key_state [3];
	logic [TBHC_TIME_BITS-1:0] pressed_at [3];
	logic [TBHC_TIME_BITS-1:0] now_count = '0;
	logic [CFG_W-1:0] set_limit = HOLD_RESET;
	logic [CFG_W-1:0] up_limit = HOLD_RESET;
	logic [CFG_W-1:0] down_limit = HOLD_RESET;
	out_item_t pending_events [$];

	int mismatches = 0;
	int events_checked = 0;
	int code_seen [8];
	int requests_sent = 0;
	int useful_requests = 0;
	int settings_used = 0;
	int hold_off = 0;
	int cycles = 0;
	bit steady = 1'b0;

	three_button_hold_combo_events_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("%0t: run limit reached with %0d events outstanding", $time,
				pending_events.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic out_item_t make_event(input logic [2:0] code);
		make_event = '{event_code: code, last_event: 1'b0};
	endfunction

	task automatic predict_request(input in_item_t req);
		logic [TBHC_TIME_BITS-1:0] held [3];
		out_item_t batch [$];
		bit up_down;
		bit down_down;
		for (int k = 0; k < 3; k++) held[k] = now_count - pressed_at[k];
		case (req.command)
			CMD_EDGE: begin
				if (req.button != BTN_NONE) begin
					if (!req.pin_level) begin
						pressed_at[req.button] = now_count;
						key_state[req.button] = ST_HOLD;
					end else if (key_state[req.button] == ST_HOLD) begin
						key_state[req.button] = ST_REL;
					end else begin
						key_state[req.button] = ST_IDLE;
					end
				end
			end
			CMD_TICK: now_count = now_count + 1'b1;
			CMD_POLL: begin
				if (key_state[BTN_DOWN] == ST_REL) begin
					batch.push_back(make_event(EV_DOWN_REL));
					key_state[BTN_DOWN] = ST_IDLE;
				end else if (key_state[BTN_DOWN] == ST_HOLD &&
						held[BTN_DOWN] > {down_limit, 1'b0}) begin
					batch.push_back(make_event(EV_DOWN_LONG));
				end
				if (key_state[BTN_UP] == ST_REL) begin
					batch.push_back(make_event(EV_UP_REL));
					key_state[BTN_UP] = ST_IDLE;
				end
				up_down = key_state[BTN_UP] == ST_HOLD;
				down_down = key_state[BTN_DOWN] == ST_HOLD;
				if (key_state[BTN_SET] == ST_HOLD && held[BTN_SET] > set_limit) begin
					if (!up_down && !down_down) begin
						batch.push_back(make_event(EV_SET_HOLD));
						key_state[BTN_SET] = ST_IDLE;
					end else if (up_down && held[BTN_UP] > up_limit) begin
						batch.push_back(make_event(EV_SET_UP));
						key_state[BTN_SET] = ST_IDLE;
						key_state[BTN_UP] = ST_IDLE;
					end else if (down_down && held[BTN_DOWN] > down_limit) begin
						batch.push_back(make_event(EV_SET_DOWN));
						key_state[BTN_SET] = ST_IDLE;
						key_state[BTN_DOWN] = ST_IDLE;
					end
				end else if (key_state[BTN_SET] == ST_REL) begin
					batch.push_back(make_event(EV_SET_REL));
					key_state[BTN_SET] = ST_IDLE;
				end
				if (batch.size() > 0) batch[batch.size() - 1].last_event = 1'b1;
				foreach (batch[k]) pending_events.push_back(batch[k]);
			end
			default: ;
		endcase
	endtask

	task automatic send_request(input logic [1:0] cmd, input logic [1:0] btn,
			input logic lvl);
		int gap;
		in_item_t req;
		req = '{command: cmd, button: btn, pin_level: lvl};
		gap = steady ? 0 : $urandom_range(4);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= req;
		push <= 1'b1;
		do @(posedge clk); while (full);
		predict_request(req);
		requests_sent++;
		if (!(cmd == CMD_NONE || (cmd == CMD_EDGE && btn == BTN_NONE))) useful_requests++;
	endtask

	task automatic press_key(input logic [1:0] btn);
		send_request(CMD_EDGE, btn, 1'b0);
	endtask

	task automatic lift_key(input logic [1:0] btn);
		send_request(CMD_EDGE, btn, 1'b1);
	endtask

	task automatic tick_ms(input int n);
		repeat (n) send_request(CMD_TICK, 2'($urandom), 1'($urandom));
	endtask

	task automatic poll_keys();
		send_request(CMD_POLL, 2'($urandom), 1'($urandom));
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (pending_events.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SET_HOLD: set_limit = val;
			REG_UP_HOLD: up_limit = val;
			REG_DOWN_HOLD: down_limit = val;
			default: ;
		endcase
	endtask

	task automatic load_limits(input logic [CFG_W-1:0] s, input logic [CFG_W-1:0] u,
			input logic [CFG_W-1:0] d);
		wait_drained();
		write_register(REG_SET_HOLD, s);
		write_register(REG_UP_HOLD, u);
		write_register(REG_DOWN_HOLD, d);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Reset thresholds stay loaded here, so only release events can fire.
	task automatic test_defaults();
		press_key(BTN_SET);
		poll_keys();
		send_request(CMD_EDGE, BTN_NONE, 1'b0);
		send_request(CMD_NONE, BTN_NONE, 1'b1);
		lift_key(BTN_SET);
		poll_keys();
		lift_key(BTN_UP);
		poll_keys();
	endtask

	task automatic test_every_event();
		load_limits('0, '0, '0);
		press_key(BTN_DOWN);
		tick_ms(1);
		poll_keys();
		lift_key(BTN_DOWN);
		poll_keys();
		press_key(BTN_UP);
		lift_key(BTN_UP);
		press_key(BTN_DOWN);
		press_key(BTN_SET);
		tick_ms(1);
		poll_keys();
		press_key(BTN_SET);
		press_key(BTN_UP);
		tick_ms(1);
		poll_keys();
		press_key(BTN_SET);
		tick_ms(1);
		poll_keys();
		press_key(BTN_SET);
		lift_key(BTN_SET);
		poll_keys();
	endtask

	task automatic test_backpressure();
		load_limits('0, '0, '0);
		press_key(BTN_DOWN);
		tick_ms(1);
		steady = 1'b1;
		hold_off = 100;
		repeat (12) poll_keys();
		steady = 1'b0;
		wait_drained();
		lift_key(BTN_DOWN);
		poll_keys();
	endtask

	task automatic test_random_sessions();
		int start;
		int session;
		int mask;
		int b;
		start = useful_requests;
		session = 0;
		while (useful_requests - start < RANDOM_REQUESTS) begin
			if (session % 3 == 0) begin
				case ((session / 3) % 4)
					1: load_limits('0, '0, '0);
					3: load_limits('1, '1, '1);
					default: load_limits(CFG_W'($urandom_range(8)),
						CFG_W'($urandom_range(8)), CFG_W'($urandom_range(8)));
				endcase
			end
			session++;
			steady = ($urandom_range(4) == 0);
			if ($urandom_range(4) == 0) begin
				repeat ($urandom_range(1, 3))
					send_request(2'($urandom), 2'($urandom), 1'($urandom));
			end else begin
				mask = $urandom_range(1, 7);
				for (b = 0; b < 3; b++) begin
					if (mask[b]) begin
						press_key(2'(b));
						tick_ms($urandom_range(2));
					end
				end
				tick_ms($urandom_range(10));
				poll_keys();
				tick_ms($urandom_range(6));
				poll_keys();
				for (b = 0; b < 3; b++) begin
					if ($urandom_range(1)) lift_key(2'(b));
				end
				poll_keys();
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_off > 0) begin
				pop <= 1'b0;
				while (hold_off > 0) begin
					@(posedge clk);
					hold_off--;
				end
			end
			stall = steady ? 0 : $urandom_range(4);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && pop && !empty) begin
			if (pending_events.size() == 0) begin
				$display("%0t: unexpected event, expected none, got code %0d last %0b",
					$time, result.event_code, result.last_event);
				mismatches++;
			end else begin
				want = pending_events.pop_front();
				if (result.event_code !== want.event_code) begin
					$display("%0t: event_code expected %0d got %0d", $time,
						want.event_code, result.event_code);
					mismatches++;
				end
				if (result.last_event !== want.last_event) begin
					$display("%0t: last_event expected %0b got %0b (code %0d)", $time,
						want.last_event, result.last_event, want.event_code);
					mismatches++;
				end
				events_checked++;
				code_seen[want.event_code]++;
			end
		end
	end

	initial begin
		for (int k = 0; k < 3; k++) begin
			key_state[k] = ST_IDLE;
			pressed_at[k] = '0;
		end
		foreach (code_seen[k]) code_seen[k] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_every_event();
		test_backpressure();
		test_random_sessions();
		wait_drained();
		repeat (8) @(posedge clk);
		$display("Sent %0d requests (%0d ignored codes) under %0d threshold settings.",
			requests_sent, requests_sent - useful_requests, settings_used + 1);
		$display("Checked %0d events: down rel %0d, down long %0d, up rel %0d, set %0d, %s",
			events_checked, code_seen[EV_DOWN_REL], code_seen[EV_DOWN_LONG],
			code_seen[EV_UP_REL], code_seen[EV_SET_HOLD],
			$sformatf("set+up %0d, set+down %0d, set rel %0d.", code_seen[EV_SET_UP],
				code_seen[EV_SET_DOWN], code_seen[EV_SET_REL]));
		if (mismatches == 0 && pending_events.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches, %0d events never seen", mismatches,
				pending_events.size());
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
`default_nettype wire
